// ----- rtl/core/assert_macros.svh -----
// Assertion macros shared by the modular exponentiation RTL.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication, checked on every rising clk edge outside reset.
`define BME_ASSERT_IMP(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) else $error(msg);

// Next-cycle implication, checked on every rising clk edge outside reset.
`define BME_ASSERT_NXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) else $error(msg);

`endif

// ----- rtl/core/bme_pkg.sv -----
// Shared types and constants for the byte modular exponentiation block.
package bme_pkg;

  localparam int MOD_BITS     = 23;
  localparam int EXP_BITS     = 32;
  localparam int BYTE_BITS    = 8;
  localparam int CFG_IDX_BITS = 2;
  localparam int CFG_DAT_BITS = 32;

  localparam logic [CFG_IDX_BITS-1:0] CFG_EXPONENT = 2'd0;
  localparam logic [CFG_IDX_BITS-1:0] CFG_MODULUS  = 2'd1;

  typedef struct packed {
    logic [BYTE_BITS-1:0] message_byte;
    logic                 is_last;
  } in_item_t;

  typedef struct packed {
    logic [MOD_BITS-1:0] residue;
    logic                last_out;
  } out_item_t;

endpackage

// ----- rtl/core/byte_modular_exponentiation.sv -----
// Top level: byte-wise modular exponentiation b^exponent mod modulus.
//
// Input: pulse start with in_data (message_byte, is_last) while busy is low;
// the byte is taken on that edge. busy rises on the next cycle unless the
// answer is immediate (exponent zero or modulus zero).
// Output: out_valid is high for exactly one cycle with out_data (residue,
// last_out). The receiver cannot stall; each byte yields one result.
// Config: cfg_valid/cfg_ready write cfg_data to register cfg_index
// (0 = exponent, 1 = modulus); cfg_ready is high while the block is idle.
// Sequence: exponent zero or modulus zero strobes the result in the cycle right
// after the accepting edge. Otherwise the byte is first reduced mod modulus,
// then square-and-multiply runs from the exponent LSB up to its highest set
// bit. Every reduction, multiply and square is one pass of the shared
// bit-serial modular multiplier, and the result strobes as the final multiply
// pass ends.
// Throughput: one byte in flight at a time; busy drops with the result strobe,
// so the next byte can be taken at the edge that ends it.
// Reset (rst_n low, synchronous) sets exponent to 1, modulus to 255 and
// drops any byte in progress.
`include "assert_macros.svh"

module byte_modular_exponentiation (
  input  logic                                 clk,
  input  logic                                 rst_n,
  input  logic                                 start,
  output logic                                 busy,
  input  bme_pkg::in_item_t                    in_data,
  output logic                                 out_valid,
  output bme_pkg::out_item_t                   out_data,
  input  logic                                 cfg_valid,
  output logic                                 cfg_ready,
  input  logic [bme_pkg::CFG_IDX_BITS-1:0]     cfg_index,
  input  logic [bme_pkg::CFG_DAT_BITS-1:0]     cfg_data
);

  localparam int MB = bme_pkg::MOD_BITS;
  localparam int EB = bme_pkg::EXP_BITS;

  typedef enum logic [1:0] {
    S_IDLE,
    S_RED,
    S_MUL,
    S_SQR
  } state_t;

  state_t         state_r;
  logic [EB-1:0]  exponent_r;
  logic [MB-1:0]  modulus_r;
  logic [EB-1:0]  exp_r;
  logic [MB-1:0]  acc_r;
  logic [MB-1:0]  sq_r;
  logic [MB-1:0]  base_r;
  logic           last_r;
  logic           go_r;
  logic           out_valid_r;
  bme_pkg::out_item_t out_data_r;

  logic [MB-1:0]  one_mod;
  logic [MB-1:0]  mm_a;
  logic [MB-1:0]  mm_b;
  logic           mm_done;
  logic [MB-1:0]  mm_p;
  logic           accept;
  logic [EB-1:0]  exp_shift;

  assign busy      = (state_r != S_IDLE);
  assign cfg_ready = !busy;
  assign accept    = start && !busy;
  assign one_mod   = (modulus_r == MB'(1)) ? '0 : MB'(1);
  assign exp_shift = {1'b0, exp_r[EB-1:1]};

  always_comb begin
    case (state_r)
      S_RED: begin
        mm_a = one_mod;
        mm_b = base_r;
      end
      S_MUL: begin
        mm_a = acc_r;
        mm_b = sq_r;
      end
      default: begin
        mm_a = sq_r;
        mm_b = sq_r;
      end
    endcase
  end

  bme_modmul u_modmul (
    .clk   (clk),
    .rst_n (rst_n),
    .go    (go_r),
    .a     (mm_a),
    .b     (mm_b),
    .n     (modulus_r),
    .done  (mm_done),
    .p     (mm_p)
  );

  // Configuration registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      exponent_r <= EB'(1);
      modulus_r  <= MB'(255);
    end else if (cfg_valid && cfg_ready) begin
      case (cfg_index)
        bme_pkg::CFG_EXPONENT: exponent_r <= cfg_data[EB-1:0];
        bme_pkg::CFG_MODULUS:  modulus_r  <= cfg_data[MB-1:0];
        default: ;
      endcase
    end
  end

  // Sequencer: reduce the byte, then walk exponent bits LSB first
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      go_r        <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      go_r        <= 1'b0;
      out_valid_r <= 1'b0;
      case (state_r)
        S_IDLE: begin
          if (accept) begin
            if (exponent_r == '0) begin
              out_valid_r <= 1'b1;
              out_data_r  <= '{residue: MB'(1), last_out: in_data.is_last};
            end else if (modulus_r == '0) begin
              out_valid_r <= 1'b1;
              out_data_r  <= '{residue: '0, last_out: in_data.is_last};
            end else begin
              state_r <= S_RED;
              go_r    <= 1'b1;
              exp_r   <= exponent_r;
              base_r  <= MB'(in_data.message_byte);
              last_r  <= in_data.is_last;
            end
          end
        end
        S_RED: begin
          if (mm_done) begin
            sq_r    <= mm_p;
            acc_r   <= one_mod;
            go_r    <= 1'b1;
            state_r <= exp_r[0] ? S_MUL : S_SQR;
          end
        end
        S_MUL: begin
          if (mm_done) begin
            acc_r <= mm_p;
            if (exp_shift == '0) begin
              state_r     <= S_IDLE;
              out_valid_r <= 1'b1;
              out_data_r  <= '{residue: mm_p, last_out: last_r};
            end else begin
              state_r <= S_SQR;
              go_r    <= 1'b1;
            end
          end
        end
        S_SQR: begin
          if (mm_done) begin
            sq_r    <= mm_p;
            exp_r   <= exp_shift;
            go_r    <= 1'b1;
            state_r <= exp_shift[0] ? S_MUL : S_SQR;
          end
        end
        default: state_r <= S_IDLE;
      endcase
    end
  end

  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;

  `BME_ASSERT_NXT(a_accept_moves, accept, busy || out_valid, "accepted byte was dropped")
  `BME_ASSERT_IMP(a_result_idle, out_valid, !busy, "result strobed while still busy")
  `BME_ASSERT_IMP(a_done_in_work, mm_done, state_r != S_IDLE, "multiplier done while idle")

endmodule

// ----- rtl/core/bme_modmul.sv -----
// Bit-serial modular multiplier: one multiplier bit per cycle, MSB first.
`include "assert_macros.svh"

module bme_modmul (
  input  logic                         clk,
  input  logic                         rst_n,
  input  logic                         go,
  input  logic [bme_pkg::MOD_BITS-1:0] a,
  input  logic [bme_pkg::MOD_BITS-1:0] b,
  input  logic [bme_pkg::MOD_BITS-1:0] n,
  output logic                         done,
  output logic [bme_pkg::MOD_BITS-1:0] p
);

  localparam int MB      = bme_pkg::MOD_BITS;
  localparam int CNT_W   = $clog2(MB);

  logic [MB-1:0]    acc_r;
  logic [MB-1:0]    mplr_r;
  logic [MB-1:0]    a_r;
  logic [CNT_W-1:0] cnt_r;
  logic             busy_r;
  logic             done_r;

  logic [MB:0] n_ext;
  logic [MB:0] dbl;
  logic [MB:0] dred;
  logic [MB:0] addend;
  logic [MB:0] sum;
  logic [MB:0] sred;
  logic [MB-1:0] acc_nxt;

  // acc = (2*acc + bit*a) mod n, both steps kept below n by one subtract
  always_comb begin
    n_ext   = {1'b0, n};
    dbl     = {acc_r, 1'b0};
    dred    = (dbl >= n_ext) ? dbl - n_ext : dbl;
    addend  = mplr_r[MB-1] ? {1'b0, a_r} : '0;
    sum     = dred + addend;
    sred    = (sum >= n_ext) ? sum - n_ext : sum;
    acc_nxt = sred[MB-1:0];
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
      cnt_r  <= '0;
    end else begin
      done_r <= 1'b0;
      if (go && !busy_r) begin
        busy_r <= 1'b1;
        cnt_r  <= CNT_W'(MB - 1);
      end else if (busy_r) begin
        cnt_r <= cnt_r - 1'b1;
        if (cnt_r == '0) begin
          busy_r <= 1'b0;
          done_r <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (go && !busy_r) begin
      acc_r  <= '0;
      mplr_r <= b;
      a_r    <= a;
    end else if (busy_r) begin
      acc_r  <= acc_nxt;
      mplr_r <= {mplr_r[MB-2:0], 1'b0};
    end
  end

  assign done = done_r;
  assign p    = acc_r;

  `BME_ASSERT_NXT(a_go_starts, go && !busy_r, busy_r, "modmul did not start on go")
  `BME_ASSERT_IMP(a_done_after_busy, done_r, !busy_r && $past(busy_r), "stray modmul done")

endmodule

// ----- verif/byte_modular_exponentiation_tb.sv -----
// Testbench for byte_modular_exponentiation: predicts every residue and checks each result.
`timescale 1ns / 100ps

module byte_modular_exponentiation_tb;

  localparam int RUN_LIMIT = 10_000_000;
  localparam int RANDOM_ITEMS = 1900;
  localparam int DRAIN_CYCLES = 100;
  localparam logic [bme_pkg::CFG_IDX_BITS-1:0] CFG_SPARE = 2'd3;

  logic clk;
  logic rst_n;
  logic start = 1'b0;
  logic busy;
  bme_pkg::in_item_t in_data = '0;
  logic out_valid;
  bme_pkg::out_item_t out_data;
  logic cfg_valid;
  logic cfg_ready;
  logic [bme_pkg::CFG_IDX_BITS-1:0] cfg_index;
  logic [bme_pkg::CFG_DAT_BITS-1:0] cfg_data;

  // Testbench copy of the key registers
  logic [bme_pkg::EXP_BITS-1:0] key_exponent;
  logic [bme_pkg::MOD_BITS-1:0] key_modulus;

  bme_pkg::in_item_t byte_queue[$];
  bme_pkg::out_item_t pending_residues[$];
  int idle_pct;
  int error_count = 0;
  int cycle_count = 0;

  byte_modular_exponentiation u_top (
    .clk       (clk),
    .rst_n     (rst_n),
    .start     (start),
    .busy      (busy),
    .in_data   (in_data),
    .out_valid (out_valid),
    .out_data  (out_data),
    .cfg_valid (cfg_valid),
    .cfg_ready (cfg_ready),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data)
  );

  always #5 clk = ~clk;

  // Left-to-right binary exponentiation, reduced after every step
  function automatic logic [bme_pkg::MOD_BITS-1:0] byte_power_mod(
      input logic [bme_pkg::BYTE_BITS-1:0] b,
      input logic [bme_pkg::EXP_BITS-1:0]  e,
      input logic [bme_pkg::MOD_BITS-1:0]  n);
    logic [63:0] acc;
    logic [63:0] n_wide;
    if (e == '0) return bme_pkg::MOD_BITS'(1);
    if (n == '0) return '0;
    n_wide = 64'(n);
    acc = 64'd1 % n_wide;
    for (int i = bme_pkg::EXP_BITS - 1; i >= 0; i--) begin
      acc = (acc * acc) % n_wide;
      if (e[i]) acc = (acc * 64'(b)) % n_wide;
    end
    return acc[bme_pkg::MOD_BITS-1:0];
  endfunction

  task automatic flag_error(input string msg);
    error_count++;
    if (error_count <= 10) $display("%0t: %s", $time, msg);
  endtask

  // Driver: hold start until the transaction is taken, then advance
  always @(posedge clk) begin : byte_driver
    logic taken;
    bme_pkg::out_item_t want;
    taken = start && !busy;
    if (!rst_n) begin
      start <= 1'b0;
    end else begin
      if (taken) begin
        want.residue = byte_power_mod(in_data.message_byte, key_exponent, key_modulus);
        want.last_out = in_data.is_last;
        pending_residues.push_back(want);
      end
      if (taken || !start) begin
        if (byte_queue.size() != 0 && $urandom_range(99) >= idle_pct) begin
          start <= 1'b1;
          in_data <= byte_queue.pop_front();
        end else begin
          start <= 1'b0;
        end
      end
    end
  end

  // Monitor: every strobed result must match the oldest prediction
  always @(posedge clk) begin : result_monitor
    bme_pkg::out_item_t want;
    if (rst_n && out_valid) begin
      if (pending_residues.size() == 0) begin
        flag_error($sformatf("unexpected result residue=%0d last=%0b",
                             out_data.residue, out_data.last_out));
      end else begin
        want = pending_residues.pop_front();
        if (out_data.residue !== want.residue || out_data.last_out !== want.last_out)
          flag_error($sformatf(
              "mismatch: expected residue=%0d last=%0b, got residue=%0d last=%0b",
              want.residue, want.last_out, out_data.residue, out_data.last_out));
      end
    end
  end

  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count >= RUN_LIMIT) begin
      $display("byte_modular_exponentiation_tb: done, errors");
      $finish;
    end
  end

  // Sample at the falling edge, once the driver's updates have settled
  task automatic wait_quiet();
    @(negedge clk);
    while (byte_queue.size() != 0 || start || pending_residues.size() != 0) @(negedge clk);
  endtask

  task automatic cfg_write(input logic [bme_pkg::CFG_IDX_BITS-1:0] idx,
                           input logic [bme_pkg::CFG_DAT_BITS-1:0] value);
    @(posedge clk);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data <= value;
    do @(posedge clk); while (!cfg_ready);
    cfg_valid <= 1'b0;
    if (idx == bme_pkg::CFG_EXPONENT) key_exponent = value;
    else if (idx == bme_pkg::CFG_MODULUS) key_modulus = value[bme_pkg::MOD_BITS-1:0];
  endtask

  task automatic load_keys(input logic [bme_pkg::EXP_BITS-1:0] e,
                           input logic [bme_pkg::CFG_DAT_BITS-1:0] n_word);
    wait_quiet();
    cfg_write(bme_pkg::CFG_EXPONENT, e);
    cfg_write(bme_pkg::CFG_MODULUS, n_word);
  endtask

  task automatic push_byte(input logic [bme_pkg::BYTE_BITS-1:0] b, input logic last);
    bme_pkg::in_item_t item;
    item.message_byte = b;
    item.is_last = last;
    byte_queue.push_back(item);
  endtask

  initial begin
    int random_sent;
    int count;
    logic [bme_pkg::EXP_BITS-1:0] e;
    logic [bme_pkg::MOD_BITS-1:0] n;
    clk = 1'b0;
    rst_n = 1'b0;
    cfg_valid = 1'b0;
    cfg_index = bme_pkg::CFG_EXPONENT;
    cfg_data = '0;
    key_exponent = 32'd1;
    key_modulus = bme_pkg::MOD_BITS'(255);
    idle_pct = 18;
    random_sent = 0;
    repeat (11) @(posedge clk);
    rst_n <= 1'b1;

    // Reset keys: exponent one, modulus 255
    push_byte(8'd0, 1'b0);
    push_byte(8'd1, 1'b1);
    push_byte(8'd254, 1'b0);
    push_byte(8'd255, 1'b1);
    push_byte(8'd128, 1'b0);

    // Exponent zero gives an unreduced 1, even for modulus one
    load_keys(32'd0, 32'd1);
    push_byte(8'd0, 1'b1);
    push_byte(8'd255, 1'b0);

    // Longest run: all exponent bits set, largest modulus
    load_keys(32'hFFFF_FFFF, 32'd8388607);
    push_byte(8'd0, 1'b0);
    push_byte(8'd1, 1'b0);
    push_byte(8'd2, 1'b1);
    push_byte(8'd255, 1'b0);
    push_byte(8'd170, 1'b1);

    // Modulus one with a nonzero exponent
    load_keys(32'd5, 32'd1);
    push_byte(8'd3, 1'b0);
    push_byte(8'd255, 1'b1);

    // Modulus zero, written with only the ignored upper bits set
    load_keys(32'd3, 32'hFF80_0000);
    push_byte(8'd7, 1'b0);
    push_byte(8'd0, 1'b1);

    // Unused register index must leave the keys alone
    wait_quiet();
    cfg_write(CFG_SPARE, 32'hFFFF_FFFF);
    load_keys(32'd65537, 32'hFF80_0CA1);
    push_byte(8'd65, 1'b0);
    push_byte(8'd255, 1'b0);
    push_byte(8'd0, 1'b0);
    push_byte(8'd1, 1'b1);

    while (random_sent < RANDOM_ITEMS) begin
      count = 100;
      case ($urandom_range(9))
        0: begin
          e = $urandom();
          count = 15;
        end
        1: e = 32'd0;
        2: e = 32'd65537;
        3: e = 32'd3;
        default: e = $urandom_range(1, 1023);
      endcase
      case ($urandom_range(5))
        0: n = bme_pkg::MOD_BITS'($urandom_range(2, 300));
        1: n = bme_pkg::MOD_BITS'(1) << $urandom_range(1, bme_pkg::MOD_BITS - 1);
        2: n = bme_pkg::MOD_BITS'(8388607);
        default: n = bme_pkg::MOD_BITS'($urandom_range(1, 8388607));
      endcase
      load_keys(e, {9'($urandom_range(0, 511)), n});
      idle_pct = (random_sent < RANDOM_ITEMS / 3) ? 18 :
                 (random_sent < 2 * RANDOM_ITEMS / 3) ? 58 : 0;
      repeat (count) push_byte(8'($urandom_range(0, 255)), $urandom_range(7) == 0);
      random_sent += count;
    end

    wait_quiet();
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (error_count == 0) begin
      $display("byte_modular_exponentiation_tb: done, clean");
    end else begin
      $display("byte_modular_exponentiation_tb: done, errors");
    end
    $finish;
  end

endmodule

// ----- sim.f -----
+incdir+rtl/core
rtl/core/bme_pkg.sv
rtl/core/bme_modmul.sv
rtl/core/byte_modular_exponentiation.sv
verif/byte_modular_exponentiation_tb.sv
